@@ hw/rtl/bone_weight_normalizer_macros.svh @@
// Assertion macros shared by the bone weight normaliser.
`ifndef BONE_WEIGHT_NORMALIZER_MACROS_SVH
`define BONE_WEIGHT_NORMALIZER_MACROS_SVH

// Same-cycle implication.
`define BWN_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("bone_weight_normalizer: same-cycle check failed");

// Next-cycle implication.
`define BWN_ASSERT_NXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("bone_weight_normalizer: next-cycle check failed");

`endif

@@ hw/rtl/bwn_pkg.sv @@
// Types, constants and register codes of the bone weight normaliser.
package bwn_pkg;

    localparam int SLOTS_PER_GROUP = 4;
    localparam int MAX_SLOTS       = 2 * SLOTS_PER_GROUP;
    localparam int WEIGHT_BITS     = 16;
    localparam int LANE_BITS       = 16;
    localparam int BONE_BITS       = 8;
    localparam int SLOT_IDX_W      = 3;
    localparam int PAIRS           = MAX_SLOTS / 2;
    localparam int PAIR_W          = WEIGHT_BITS + 1;
    localparam int SUM_W           = WEIGHT_BITS + 3;
    localparam int NUM_W           = 2 * WEIGHT_BITS;
    localparam int DIV_STEP        = 2;
    localparam int DIV_STAGES      = (WEIGHT_BITS + DIV_STEP - 1) / DIV_STEP;
    localparam int QUO_W           = DIV_STEP * DIV_STAGES;
    localparam int DATA_W          = MAX_SLOTS * (LANE_BITS + BONE_BITS);
    localparam int USER_W          = 2;
    localparam int CFG_ADDR_W      = 3;
    localparam int CFG_DATA_W      = 16;
    localparam int COUNT_W         = 4;
    localparam int EPS_W           = 16;
    localparam int CMP_W           = (SUM_W > EPS_W) ? SUM_W : EPS_W;

    localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE = WEIGHT_BITS'(1) << (WEIGHT_BITS - 1);

    typedef enum logic [USER_W-1:0] {
        ACT_NORM = 2'd0,
        ACT_FILL = 2'd1,
        ACT_PASS = 2'd2
    } action_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_ENABLE    = 3'd0,
        CFG_USE_EXTRA = 3'd1,
        CFG_INF_COUNT = 3'd2,
        CFG_NO_INF    = 3'd3,
        CFG_EPSILON   = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic                 enable;
        logic                 use_extra;
        logic [COUNT_W-1:0]   inf_count;
        logic [BONE_BITS-1:0] no_inf_bone;
        logic [EPS_W-1:0]     epsilon;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        enable:      1'b1,
        use_extra:   1'b0,
        inf_count:   4'd4,
        no_inf_bone: 8'd0,
        epsilon:     16'd33
    };

    typedef logic [MAX_SLOTS-1:0][LANE_BITS-1:0]   lanes_t;
    typedef logic [MAX_SLOTS-1:0][BONE_BITS-1:0]   bones_t;
    typedef logic [MAX_SLOTS-1:0][WEIGHT_BITS-1:0] wvec_t;

    typedef struct packed {
        action_t action;
        lanes_t  wts;
        bones_t  bones;
    } side_t;

    typedef struct packed {
        logic                              valid;
        logic [MAX_SLOTS-1:0][NUM_W-1:0]   num;
        logic [SUM_W-1:0]                  den;
        side_t                             side;
    } div_req_t;

    typedef struct packed {
        logic  valid;
        wvec_t quo;
        side_t side;
    } div_rsp_t;

    typedef struct packed {
        logic out_valid;
        logic skid_valid;
    } out_stat_t;

endpackage

@@ hw/rtl/bwn_front.sv @@
// Front stages: lane masking, weight sum, slot choice and divider operands.
module bwn_front import bwn_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  cfg_t              cfg,
    input  logic              in_valid,
    input  logic [DATA_W-1:0] in_data,
    output div_req_t          req
);

    lanes_t                           in_w;
    bones_t                           in_b;
    wvec_t                            wm_next;
    logic [MAX_SLOTS-1:0]             low_next;
    logic [PAIRS-1:0][PAIR_W-1:0]     pair_next;

    logic                             s1_valid_reg;
    lanes_t                           s1_w_reg;
    bones_t                           s1_b_reg;
    wvec_t                            s1_wm_reg;
    logic [MAX_SLOTS-1:0]             s1_low_reg;
    logic [PAIRS-1:0][PAIR_W-1:0]     s1_pair_reg;

    logic [SUM_W-1:0]                 sum_next;
    logic [SLOT_IDX_W-1:0]            slot_next;
    logic [SLOT_IDX_W-1:0]            first_slot;
    logic [COUNT_W-1:0]               limit;

    logic                             s2_valid_reg;
    lanes_t                           s2_w_reg;
    bones_t                           s2_b_reg;
    wvec_t                            s2_wm_reg;
    logic [SUM_W-1:0]                 s2_sum_reg;
    logic [SLOT_IDX_W-1:0]            s2_slot_reg;

    logic [MAX_SLOTS-1:0][NUM_W-1:0]  num_next;
    logic [WEIGHT_BITS-1:0]           fill_w;
    side_t                            side_next;

    logic                             s3_valid_reg;
    logic [MAX_SLOTS-1:0][NUM_W-1:0]  s3_num_reg;
    logic [SUM_W-1:0]                 s3_den_reg;
    side_t                            s3_side_reg;

    assign {in_b, in_w} = in_data;

    always_comb
    begin
        for (int i = 0; i < MAX_SLOTS; i++)
        begin
            wm_next[i] = in_w[i][WEIGHT_BITS-1:0];
            if (i >= SLOTS_PER_GROUP && !cfg.use_extra)
            begin
                wm_next[i] = '0;
            end
            low_next[i] = (CMP_W'(wm_next[i]) < CMP_W'(cfg.epsilon))
                          && (i < SLOTS_PER_GROUP || cfg.use_extra);
        end
        for (int p = 0; p < PAIRS; p++)
        begin
            pair_next[p] = PAIR_W'(wm_next[2*p]) + PAIR_W'(wm_next[2*p+1]);
        end
    end

    always_comb
    begin
        sum_next = (SUM_W'(s1_pair_reg[0]) + SUM_W'(s1_pair_reg[1]))
                 + (SUM_W'(s1_pair_reg[2]) + SUM_W'(s1_pair_reg[3]));
        first_slot = '0;
        for (int i = MAX_SLOTS - 1; i >= 0; i--)
        begin
            if (s1_low_reg[i])
            begin
                first_slot = SLOT_IDX_W'(i);
            end
        end
        limit = (cfg.inf_count == '0) ? '0 : cfg.inf_count - COUNT_W'(1);
        if (limit > COUNT_W'(MAX_SLOTS - 1))
        begin
            limit = COUNT_W'(MAX_SLOTS - 1);
        end
        if (!cfg.use_extra && limit > COUNT_W'(SLOTS_PER_GROUP - 1))
        begin
            limit = COUNT_W'(SLOTS_PER_GROUP - 1);
        end
        if (!(|s1_low_reg) || COUNT_W'(first_slot) > limit)
        begin
            slot_next = limit[SLOT_IDX_W-1:0];
        end
        else
        begin
            slot_next = first_slot;
        end
    end

    always_comb
    begin
        for (int i = 0; i < MAX_SLOTS; i++)
        begin
            num_next[i] = (NUM_W'(s2_wm_reg[i]) << (WEIGHT_BITS - 1))
                        + NUM_W'(s2_sum_reg >> 1);
        end
        if (s2_sum_reg > SUM_W'(WEIGHT_ONE))
        begin
            fill_w = '0;
        end
        else
        begin
            fill_w = WEIGHT_BITS'(SUM_W'(WEIGHT_ONE) - s2_sum_reg);
        end
        if (!cfg.enable)
        begin
            side_next.action = ACT_PASS;
            side_next.wts    = s2_w_reg;
            side_next.bones  = s2_b_reg;
        end
        else
        begin
            for (int i = 0; i < MAX_SLOTS; i++)
            begin
                side_next.wts[i]   = LANE_BITS'(s2_wm_reg[i]);
                side_next.bones[i] = (i >= SLOTS_PER_GROUP && !cfg.use_extra) ?
                                     '0 : s2_b_reg[i];
            end
            if (CMP_W'(s2_sum_reg) > CMP_W'(cfg.epsilon))
            begin
                side_next.action = ACT_NORM;
            end
            else
            begin
                side_next.action              = ACT_FILL;
                side_next.wts[s2_slot_reg]    = LANE_BITS'(fill_w);
                side_next.bones[s2_slot_reg]  = cfg.no_inf_bone;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_w_reg    <= in_w;
            s1_b_reg    <= in_b;
            s1_wm_reg   <= wm_next;
            s1_low_reg  <= low_next;
            s1_pair_reg <= pair_next;
            s2_w_reg    <= s1_w_reg;
            s2_b_reg    <= s1_b_reg;
            s2_wm_reg   <= s1_wm_reg;
            s2_sum_reg  <= sum_next;
            s2_slot_reg <= slot_next;
            s3_num_reg  <= num_next;
            s3_den_reg  <= s2_sum_reg;
            s3_side_reg <= side_next;
        end
    end

    assign req.valid = s3_valid_reg;
    assign req.num   = s3_num_reg;
    assign req.den   = s3_den_reg;
    assign req.side  = s3_side_reg;

endmodule

@@ hw/rtl/bwn_div.sv @@
// Pipelined restoring divider for all weight lanes, two quotient bits a stage.
module bwn_div import bwn_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     adv,
    input  div_req_t req,
    output div_rsp_t rsp
);

    typedef struct packed {
        logic [MAX_SLOTS-1:0][SUM_W-1:0] rem;
        logic [MAX_SLOTS-1:0][QUO_W-1:0] nlow;
        logic [MAX_SLOTS-1:0][QUO_W-1:0] quo;
        logic [SUM_W-1:0]                den;
        side_t                           side;
    } div_stage_t;

    logic [DIV_STAGES-1:0] vld_reg;
    div_stage_t            stage_reg  [DIV_STAGES];
    div_stage_t            stage_next [DIV_STAGES];

    always_comb
    begin
        div_stage_t       cur;
        logic [SUM_W:0]   t;
        logic [SUM_W-1:0] r;
        logic [QUO_W-1:0] n;
        logic [QUO_W-1:0] q;
        for (int k = 0; k < DIV_STAGES; k++)
        begin
            if (k == 0)
            begin
                cur.den  = req.den;
                cur.side = req.side;
                for (int l = 0; l < MAX_SLOTS; l++)
                begin
                    cur.rem[l]  = SUM_W'(req.num[l] >> QUO_W);
                    cur.nlow[l] = req.num[l][QUO_W-1:0];
                    cur.quo[l]  = '0;
                end
            end
            else
            begin
                cur = stage_reg[k-1];
            end
            stage_next[k].den  = cur.den;
            stage_next[k].side = cur.side;
            for (int l = 0; l < MAX_SLOTS; l++)
            begin
                r = cur.rem[l];
                n = cur.nlow[l];
                q = cur.quo[l];
                for (int j = 0; j < DIV_STEP; j++)
                begin
                    t = {r, n[QUO_W-1]};
                    n = {n[QUO_W-2:0], 1'b0};
                    if (t >= {1'b0, cur.den})
                    begin
                        t = t - {1'b0, cur.den};
                        q = {q[QUO_W-2:0], 1'b1};
                    end
                    else
                    begin
                        q = {q[QUO_W-2:0], 1'b0};
                    end
                    r = t[SUM_W-1:0];
                end
                stage_next[k].rem[l]  = r;
                stage_next[k].nlow[l] = n;
                stage_next[k].quo[l]  = q;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[DIV_STAGES-2:0], req.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < DIV_STAGES; k++)
            begin
                stage_reg[k] <= stage_next[k];
            end
        end
    end

    always_comb
    begin
        rsp.valid = vld_reg[DIV_STAGES-1];
        rsp.side  = stage_reg[DIV_STAGES-1].side;
        for (int l = 0; l < MAX_SLOTS; l++)
        begin
            rsp.quo[l] = stage_reg[DIV_STAGES-1].quo[l][WEIGHT_BITS-1:0];
        end
    end

endmodule

@@ hw/rtl/bwn_out.sv @@
// Result assembly, output register and skid register.
module bwn_out import bwn_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  div_rsp_t          rsp,
    input  logic              m_tready,
    output logic              m_tvalid,
    output logic [DATA_W-1:0] m_tdata,
    output logic [USER_W-1:0] m_tuser,
    output out_stat_t         stat
);

    lanes_t            item_wts;
    logic [DATA_W-1:0] item_data;
    logic              push;
    logic              pop;

    logic              out_valid_reg;
    logic              skid_valid_reg;
    logic [DATA_W-1:0] out_data_reg;
    action_t           out_user_reg;
    logic [DATA_W-1:0] skid_data_reg;
    action_t           skid_user_reg;

    always_comb
    begin
        for (int l = 0; l < MAX_SLOTS; l++)
        begin
            item_wts[l] = (rsp.side.action == ACT_NORM) ?
                          LANE_BITS'(rsp.quo[l]) : rsp.side.wts[l];
        end
        item_data = {rsp.side.bones, item_wts};
    end

    assign push = rsp.valid && !skid_valid_reg;
    assign pop  = out_valid_reg && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_reg <= skid_data_reg;
                out_user_reg <= skid_user_reg;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_data_reg <= item_data;
                out_user_reg <= rsp.side.action;
            end
            else
            begin
                skid_data_reg <= item_data;
                skid_user_reg <= rsp.side.action;
            end
        end
    end

    assign m_tvalid        = out_valid_reg;
    assign m_tdata         = out_data_reg;
    assign m_tuser         = out_user_reg;
    assign stat.out_valid  = out_valid_reg;
    assign stat.skid_valid = skid_valid_reg;

endmodule

@@ hw/rtl/bone_weight_normalizer.sv @@
// An accepted request passes 3 front, 8 divider and 1 output register stages on its way to m_tvalid.
// Throughput: one vertex per cycle while s_tready is high; the divider stages set the latency, not the rate.
// s_tready drops only while the skid register holds a result; the pipeline then freezes.
// Reset: asynchronous, active low; clears all valid bits and loads register defaults.
// No clearing pass after reset: requests are taken in the first cycle after release.
module bone_weight_normalizer import bwn_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // weights_first, weights_extra, bones_first, bones_extra
    input  logic [DATA_W-1:0]     s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // weights_first_out, weights_extra_out, bones_first_out, bones_extra_out
    output logic [DATA_W-1:0]     m_tdata,
    // action
    output logic [USER_W-1:0]     m_tuser,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    `include "bone_weight_normalizer_macros.svh"

    cfg_t      cfg_reg;
    logic      adv;
    div_req_t  div_req;
    div_rsp_t  div_rsp;
    out_stat_t stat;
    logic      norm_over;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_ENABLE:    cfg_reg.enable      <= cfg_wdata[0];
                CFG_USE_EXTRA: cfg_reg.use_extra   <= cfg_wdata[0];
                CFG_INF_COUNT: cfg_reg.inf_count   <= cfg_wdata[COUNT_W-1:0];
                CFG_NO_INF:    cfg_reg.no_inf_bone <= cfg_wdata[BONE_BITS-1:0];
                CFG_EPSILON:   cfg_reg.epsilon     <= cfg_wdata[EPS_W-1:0];
                default:       ;
            endcase
        end
    end

    assign adv      = !stat.skid_valid;
    assign s_tready = adv;

    bwn_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .cfg      (cfg_reg),
        .in_valid (s_tvalid),
        .in_data  (s_tdata),
        .req      (div_req)
    );

    bwn_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    bwn_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .rsp      (div_rsp),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .stat     (stat)
    );

    always_comb
    begin
        norm_over = 1'b0;
        for (int l = 0; l < MAX_SLOTS; l++)
        begin
            if (m_tdata[l*LANE_BITS +: LANE_BITS] > LANE_BITS'(WEIGHT_ONE))
            begin
                norm_over = 1'b1;
            end
        end
    end

    `BWN_ASSERT_IMP(a_skid_needs_out, clk, rst_n, stat.skid_valid, m_tvalid)
    `BWN_ASSERT_NXT(a_skid_catch, clk, rst_n, div_rsp.valid && adv && m_tvalid && !m_tready, stat.skid_valid)
    `BWN_ASSERT_IMP(a_norm_bound, clk, rst_n, m_tvalid && (m_tuser == ACT_NORM), !norm_over)

endmodule
